// ===== hdl/wbps_pkg.sv =====
package wbps_pkg;

    localparam int BYTE_W   = 8;
    localparam int OFFSET_W = 24;
    localparam int LEN_W    = 5;
    localparam int DATA_W   = 64;
    localparam int ADDR_W   = 5;

    typedef enum logic [1:0] {
        REG_PATTERN_LOW  = 2'd0,
        REG_PATTERN_HIGH = 2'd1,
        REG_PATTERN_LEN  = 2'd2,
        REG_WILDCARD     = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [BYTE_W-1:0] region_byte;
        logic              region_last;
    } item_t;

    typedef struct packed {
        logic                match_found;
        logic [OFFSET_W-1:0] match_offset;
    } result_t;

    typedef struct packed {
        logic [DATA_W-1:0] pattern_low_word;
        logic [DATA_W-1:0] pattern_high_word;
        logic [LEN_W-1:0]  pattern_length;
        logic [BYTE_W-1:0] wildcard_byte;
    } cfg_t;

    // byte position and end marker that travel with the shifted window
    typedef struct packed {
        logic [OFFSET_W-1:0] pos;
        logic                last;
    } stage_t;

endpackage

// ===== hdl/wbps_regs.sv =====
module wbps_regs
    import wbps_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ADDR_W-1:0]         paddr,
    input  logic [DATA_W-1:0]         pwdata,
    output logic [DATA_W-1:0]         prdata,
    output logic                      pready,
    output cfg_t                      cfg
);

    cfg_t       cfg_reg;
    reg_index_t index;
    logic       wr_en;

    assign index  = reg_index_t'(paddr[ADDR_W-1:3]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pattern_low_word  <= '0;
            cfg_reg.pattern_high_word <= '0;
            cfg_reg.pattern_length    <= LEN_W'(1);
            cfg_reg.wildcard_byte     <= '0;
        end
        else if (wr_en)
        begin
            case (index)
                REG_PATTERN_LOW:  cfg_reg.pattern_low_word  <= pwdata;
                REG_PATTERN_HIGH: cfg_reg.pattern_high_word <= pwdata;
                REG_PATTERN_LEN:  cfg_reg.pattern_length    <= pwdata[LEN_W-1:0];
                REG_WILDCARD:     cfg_reg.wildcard_byte     <= pwdata[BYTE_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            REG_PATTERN_LOW:  prdata = cfg_reg.pattern_low_word;
            REG_PATTERN_HIGH: prdata = cfg_reg.pattern_high_word;
            REG_PATTERN_LEN:  prdata = DATA_W'(cfg_reg.pattern_length);
            REG_WILDCARD:     prdata = DATA_W'(cfg_reg.wildcard_byte);
            default:          prdata = '0;
        endcase
    end

endmodule

// ===== hdl/wbps_window.sv =====
module wbps_window
    import wbps_pkg::*;
#(
    parameter int PATTERN_MAX      = 16,
    parameter int REGION_MAX_BYTES = 16777216
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_ready,
    input  item_t                              item,
    output logic                               stage_valid,
    input  logic                               stage_ready,
    output stage_t                             stage,
    output logic [PATTERN_MAX-1:0][BYTE_W-1:0] window
);

    localparam logic [OFFSET_W-1:0] POS_LIMIT = OFFSET_W'(REGION_MAX_BYTES - 1);

    logic [PATTERN_MAX-1:0][BYTE_W-1:0] window_reg, window_next, window_base;
    logic [OFFSET_W-1:0]                count_reg, count_next, count_base;
    logic                               clear_reg;
    logic                               valid_reg;
    stage_t                             stage_reg;
    logic                               accept;

    assign item_ready  = !valid_reg || stage_ready;
    assign accept      = item_valid && item_ready;
    assign stage_valid = valid_reg;
    assign stage       = stage_reg;
    assign window      = window_reg;

    // after a region's final byte the scan restarts from an empty window
    assign window_base = clear_reg ? '0 : window_reg;
    assign count_base  = clear_reg ? '0 : count_reg;

    always_comb
    begin
        window_next[0] = item.region_byte;
        for (int k = 1; k < PATTERN_MAX; k++)
        begin
            window_next[k] = window_base[k-1];
        end
        count_next = (count_base < POS_LIMIT) ? count_base + OFFSET_W'(1) : count_base;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            count_reg  <= '0;
            clear_reg  <= 1'b0;
            valid_reg  <= 1'b0;
            stage_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                window_reg     <= window_next;
                count_reg      <= count_next;
                clear_reg      <= item.region_last;
                stage_reg.pos  <= count_base;
                stage_reg.last <= item.region_last;
                valid_reg      <= 1'b1;
            end
            else if (stage_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== hdl/wbps_match.sv =====
module wbps_match
    import wbps_pkg::*;
#(
    parameter int PATTERN_MAX = 16
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  cfg_t                               cfg,
    input  logic                               stage_valid,
    output logic                               stage_ready,
    input  stage_t                             stage,
    input  logic [PATTERN_MAX-1:0][BYTE_W-1:0] window,
    output logic                               result_valid,
    input  logic                               result_ready,
    output result_t                            result
);

    localparam int               IDX_W    = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam logic [LEN_W-1:0] IDX_MASK = LEN_W'(PATTERN_MAX - 1);
    localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(PATTERN_MAX);

    logic [2*DATA_W-1:0] pattern;
    logic [LEN_W-1:0]    len;
    logic [LEN_W-1:0]    idx;
    logic [BYTE_W-1:0]   pat_byte;
    logic                hit;
    logic                fits;
    logic                found_now;
    logic                found_next;
    logic [OFFSET_W-1:0] offset_now;
    logic [OFFSET_W-1:0] offset_next;
    logic [OFFSET_W:0]   pos_plus;
    logic                out_space;
    logic                fire;

    logic                found_reg;
    logic [OFFSET_W-1:0] offset_reg;
    logic                out_valid_reg;
    result_t             out_reg;

    assign pattern = {cfg.pattern_high_word, cfg.pattern_low_word};

    always_comb
    begin
        if (cfg.pattern_length == '0)
            len = LEN_W'(1);
        else if (cfg.pattern_length > LEN_MAX)
            len = LEN_MAX;
        else
            len = cfg.pattern_length;
    end

    // pattern byte j lines up with the window entry that is len-1-j bytes old
    always_comb
    begin
        hit      = 1'b1;
        idx      = '0;
        pat_byte = '0;
        for (int j = 0; j < PATTERN_MAX; j++)
        begin
            pat_byte = pattern[8*j +: 8];
            idx      = (len - LEN_W'(1) - LEN_W'(j)) & IDX_MASK;
            if (LEN_W'(j) < len && pat_byte != cfg.wildcard_byte
                && pat_byte != window[idx[IDX_W-1:0]])
                hit = 1'b0;
        end
    end

    assign pos_plus    = {1'b0, stage.pos} + (OFFSET_W+1)'(1);
    assign fits        = pos_plus >= (OFFSET_W+1)'(len);
    assign found_now   = !found_reg && fits && hit;
    assign offset_now  = OFFSET_W'(pos_plus - (OFFSET_W+1)'(len));
    assign found_next  = found_reg || found_now;
    assign offset_next = found_reg ? offset_reg : offset_now;

    assign out_space    = !out_valid_reg || result_ready;
    assign stage_ready  = !stage.last || out_space;
    assign fire         = stage_valid && stage_ready;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg     <= 1'b0;
            offset_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire && stage.last)
            begin
                found_reg     <= 1'b0;
                offset_reg    <= '0;
                out_valid_reg <= 1'b1;
            end
            else
            begin
                if (fire)
                begin
                    found_reg  <= found_next;
                    offset_reg <= offset_next;
                end
                if (result_ready)
                    out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && stage.last)
        begin
            out_reg.match_found  <= found_next;
            out_reg.match_offset <= found_next ? offset_next : '0;
        end
    end

endmodule

// ===== hdl/wildcard_byte_pattern_search.sv =====
// A region's result is registered once its final byte has passed the window stage.
// Throughput: one byte per cycle; the window shift and the parallel compare
// each take one register stage; only a final byte waits while the previous result is unread.
// Reset (rst_n, async, active low): the configuration registers return to their defaults,
// the window, byte count and match state clear, and no result is pending.
module wildcard_byte_pattern_search
    import wbps_pkg::*;
#(
    parameter int PATTERN_MAX      = 16,
    parameter int REGION_MAX_BYTES = 16777216
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              item_valid,
    output logic              item_ready,
    input  item_t             item,
    output logic              result_valid,
    input  logic              result_ready,
    output result_t           result
);

    cfg_t                               cfg;
    logic                               stage_valid;
    logic                               stage_ready;
    stage_t                             stage;
    logic [PATTERN_MAX-1:0][BYTE_W-1:0] window;

    wbps_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    wbps_window #(
        .PATTERN_MAX      (PATTERN_MAX),
        .REGION_MAX_BYTES (REGION_MAX_BYTES)
    ) u_window (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .stage_valid (stage_valid),
        .stage_ready (stage_ready),
        .stage       (stage),
        .window      (window)
    );

    wbps_match #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_match (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .stage_valid  (stage_valid),
        .stage_ready  (stage_ready),
        .stage        (stage),
        .window       (window),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
